// File: rtl/mcsp_pkg.sv
// Package for the servo PWM core: widths, codes, state and command types.
`default_nettype none

package mcsp_pkg;

   localparam int NUM_CHANNELS = 18;

   localparam int PIN_W      = 18;
   localparam int DUTY_W     = 10;
   localparam int CNT_W      = 16;
   localparam int DEG_W      = 10;
   localparam int RES_W      = 16;
   localparam int CHAN_W     = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;
   localparam int RAD_W      = 14;
   localparam int RDEG_W     = DEG_W + RAD_W;
   localparam int PROD_W     = CNT_W + RES_W;
   localparam int SUM_W      = PROD_W - 8 + 1;

   localparam int NUM_LIVE = (NUM_CHANNELS < PIN_W) ? NUM_CHANNELS : PIN_W;

   localparam logic [PIN_W-1:0] LIVE_MASK = PIN_W'((64'd1 << NUM_CHANNELS) - 64'd1);

   localparam logic [RAD_W-1:0]  RAD_TO_DEG_Q8 = RAD_W'(14668);
   localparam logic [DUTY_W-1:0] DUTY_MAX      = {DUTY_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DUTY = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DUTY = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DEG  = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DEG  = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_RES      = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE   = CSR_IDX_W'(6);

   localparam logic OP_TICK      = 1'b0;
   localparam logic OP_SET_ANGLE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK,
      ST_DEG,
      ST_MUL,
      ST_DUTY
   } state_type;

   typedef struct packed {
      logic capture;
      logic load_deg;
      logic load_prod;
      logic commit_tick;
      logic commit_angle;
   } cmd_type;

endpackage

`default_nettype wire

// File: rtl/multi_channel_servo_pwm_core.sv
// Top level of the multi-channel servo PWM core: controller plus datapath.
//
//   Channel   Ports                         Direction   Word
//   req       req_valid/req_ready + fields  in          tick or set-angle
//   rsp       rsp_valid/rsp_ready + fields  out         pin levels, duty written
//   csr       csr_we/csr_index/csr_wdata    in          register write
//
// A tick word passes through the accept and the commit, and its result word is
// registered at the commit. A set-angle word passes through the accept, the radian
// scaling multiply, the resolution multiply and the commit, and its result word is
// registered at the commit. One word is in work at a time.
// Reset is synchronous; there is no clearing pass.
// The commit cycle waits while the result register holds a word not yet taken.
`default_nettype none

module multi_channel_servo_pwm_core (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire                                 req_op,
   input  wire  [mcsp_pkg::CHAN_W-1:0]         req_channel,
   input  wire  [mcsp_pkg::DEG_W-1:0]          req_angle,
   input  wire                                 req_angle_in_radians,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic [mcsp_pkg::PIN_W-1:0]          rsp_pin_levels,
   output logic [mcsp_pkg::DUTY_W-1:0]         rsp_duty_written,
   input  wire                                 csr_we,
   input  wire  [mcsp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [mcsp_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import mcsp_pkg::*;

   cmd_type cmd;
   logic    out_free;

   mcsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .out_free  (out_free),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   mcsp_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_channel          (req_channel),
      .req_angle            (req_angle),
      .req_angle_in_radians (req_angle_in_radians),
      .cmd                  (cmd),
      .rsp_ready            (rsp_ready),
      .out_free             (out_free),
      .rsp_valid            (rsp_valid),
      .rsp_pin_levels       (rsp_pin_levels),
      .rsp_duty_written     (rsp_duty_written)
   );

endmodule

`default_nettype wire

// File: rtl/mcsp_ctrl.sv
// Controller state machine that sequences tick and set-angle words.
`default_nettype none

module mcsp_ctrl (
   input  wire             clock,
   input  wire             reset,
   input  wire             req_valid,
   input  wire             req_op,
   input  wire             out_free,
   output logic            req_ready,
   output mcsp_pkg::cmd_type cmd
);
   import mcsp_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = (req_op == OP_TICK) ? ST_TICK : ST_DEG;
            end
         end
         ST_TICK: begin
            if (out_free) begin
               cmd.commit_tick = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_DEG: begin
            cmd.load_deg = 1'b1;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            cmd.load_prod = 1'b1;
            state_in      = ST_DUTY;
         end
         ST_DUTY: begin
            if (out_free) begin
               cmd.commit_angle = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/mcsp_dp.sv
// Datapath: registers, tick counter, duty store, angle conversion and result word.
`default_nettype none

module mcsp_dp (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_we,
   input  wire  [mcsp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [mcsp_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire  [mcsp_pkg::CHAN_W-1:0]         req_channel,
   input  wire  [mcsp_pkg::DEG_W-1:0]          req_angle,
   input  wire                                 req_angle_in_radians,
   input  mcsp_pkg::cmd_type                   cmd,
   input  wire                                 rsp_ready,
   output logic                                out_free,
   output logic                                rsp_valid,
   output logic [mcsp_pkg::PIN_W-1:0]          rsp_pin_levels,
   output logic [mcsp_pkg::DUTY_W-1:0]         rsp_duty_written
);
   import mcsp_pkg::*;

   logic [CNT_W-1:0]  period_ff;
   logic [DUTY_W-1:0] min_duty_ff;
   logic [DUTY_W-1:0] max_duty_ff;
   logic [DEG_W-1:0]  min_deg_ff;
   logic [DEG_W-1:0]  max_deg_ff;
   logic [RES_W-1:0]  res_ff;
   logic [PIN_W-1:0]  enable_ff;

   logic [CHAN_W-1:0] chan_ff;
   logic [DEG_W-1:0]  angle_ff;
   logic              rad_ff;
   logic [CNT_W-1:0]  deg_ff;
   logic [CNT_W-1:0]  deg_in;
   logic [PROD_W-1:0] prod_ff;
   logic              lt_ff;
   logic              gt_ff;

   logic [CNT_W-1:0]  tick_ff;
   logic [CNT_W-1:0]  tick_in;
   logic [DUTY_W-1:0] duty_ff [PIN_W];
   logic [PIN_W-1:0]  pin_ff;
   logic [PIN_W-1:0]  pin_in;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [PIN_W-1:0]  rsp_pins_ff;
   logic [DUTY_W-1:0] rsp_duty_ff;
   logic [DUTY_W-1:0] written_in;

   logic [PIN_W-1:0]  live;
   logic [RDEG_W-1:0] rad_prod;
   logic [SUM_W-1:0]  lin_sum;
   logic [DUTY_W-1:0] lin_duty;
   logic [DUTY_W-1:0] angle_duty;
   logic              chan_ok;
   logic              commit;

   assign live     = enable_ff & LIVE_MASK;
   assign commit   = cmd.commit_tick | cmd.commit_angle;
   assign out_free = ~rsp_valid_ff | rsp_ready;

   assign rad_prod = RDEG_W'(angle_ff) * RDEG_W'(RAD_TO_DEG_Q8);
   assign deg_in   = rad_ff ? CNT_W'(rad_prod >> 8) : CNT_W'(angle_ff);

   assign lin_sum    = SUM_W'(prod_ff[PROD_W-1:8]) + SUM_W'(min_duty_ff);
   assign lin_duty   = (lin_sum > SUM_W'(DUTY_MAX)) ? DUTY_MAX : lin_sum[DUTY_W-1:0];
   assign angle_duty = lt_ff ? min_duty_ff : (gt_ff ? max_duty_ff : lin_duty);
   assign chan_ok    = (32'(chan_ff) < 32'(NUM_LIVE));

   always_comb begin
      tick_in    = tick_ff;
      pin_in     = pin_ff & live;
      written_in = '0;
      if (cmd.commit_tick) begin
         if (tick_ff < period_ff) begin
            tick_in = tick_ff + CNT_W'(1);
         end else begin
            tick_in = '0;
            pin_in  = pin_in | live;
         end
         if (tick_in <= CNT_W'(max_duty_ff)) begin
            for (int ch = 0; ch < PIN_W; ch++) begin
               if (live[ch] && (CNT_W'(duty_ff[ch]) == tick_in)) begin
                  pin_in[ch] = 1'b0;
               end
            end
         end
      end
      if (cmd.commit_angle && chan_ok) begin
         written_in = angle_duty;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= CNT_W'(3999);
         min_duty_ff  <= DUTY_W'(200);
         max_duty_ff  <= DUTY_W'(400);
         min_deg_ff   <= DEG_W'(0);
         max_deg_ff   <= DEG_W'(180);
         res_ff       <= RES_W'(284);
         enable_ff    <= '0;
         tick_ff      <= '0;
         pin_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < PIN_W; i++) begin
            duty_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PERIOD:   period_ff   <= csr_wdata[CNT_W-1:0];
               CSR_MIN_DUTY: min_duty_ff <= csr_wdata[DUTY_W-1:0];
               CSR_MAX_DUTY: max_duty_ff <= csr_wdata[DUTY_W-1:0];
               CSR_MIN_DEG:  min_deg_ff  <= csr_wdata[DEG_W-1:0];
               CSR_MAX_DEG:  max_deg_ff  <= csr_wdata[DEG_W-1:0];
               CSR_RES:      res_ff      <= csr_wdata[RES_W-1:0];
               CSR_ENABLE:   enable_ff   <= csr_wdata[PIN_W-1:0];
               default: begin
               end
            endcase
         end
         if (commit) begin
            tick_ff <= tick_in;
            pin_ff  <= pin_in;
         end
         if (cmd.commit_angle && chan_ok) begin
            duty_ff[chan_ff] <= angle_duty;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         chan_ff  <= req_channel;
         angle_ff <= req_angle;
         rad_ff   <= req_angle_in_radians;
      end
      if (cmd.load_deg) begin
         deg_ff <= deg_in;
      end
      if (cmd.load_prod) begin
         prod_ff <= PROD_W'(deg_ff) * PROD_W'(res_ff);
         lt_ff   <= (deg_ff < CNT_W'(min_deg_ff));
         gt_ff   <= (deg_ff > CNT_W'(max_deg_ff));
      end
      if (commit) begin
         rsp_pins_ff <= pin_in;
         rsp_duty_ff <= written_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pin_levels   = rsp_pins_ff;
   assign rsp_duty_written = rsp_duty_ff;

endmodule

`default_nettype wire

// File: rtl/mcsp_checker.sv
// Port-level checker for the servo PWM core and its bind to the top level.
`default_nettype none

module mcsp_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_valid,
   input wire                          req_ready,
   input wire                          rsp_valid,
   input wire                          rsp_ready,
   input wire [mcsp_pkg::PIN_W-1:0]    rsp_pin_levels,
   input wire [mcsp_pkg::DUTY_W-1:0]   rsp_duty_written
);
   import mcsp_pkg::*;

   // A waiting result word holds still until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pin_levels)
                                  && $stable(rsp_duty_written))
      else $error("result word changed while stalled");

   // Reset leaves the core idle with no result pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("core not idle after reset");

   // A taken word leaves the input side busy in the cycle after it is taken.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken again without processing");

   // A new result word only appears right after the core was busy with a word.
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result word appeared without a word in work");

endmodule

bind multi_channel_servo_pwm_core mcsp_checker u_mcsp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_pin_levels   (rsp_pin_levels),
   .rsp_duty_written (rsp_duty_written)
);

`default_nettype wire
